>>> design/tovl_pkg.sv
// Package for the topology order validator: node and verdict types, codes.
// No dependencies; used by tovl_check and topology_order_validator_top.
`timescale 1ns / 1ps

package tovl_pkg;

  localparam logic [15:0] NO_PARENT      = 16'hFFFF;
  localparam logic [7:0]  TYPE_UNDEFINED = 8'd0;
  localparam logic [7:0]  TYPE_PROCESSOR = 8'd1;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_TOO_DEEP      = 3'd1,
    ERR_BAD_ORDER     = 3'd2,
    ERR_PARENT        = 3'd3,
    ERR_LEAF_NOT_PROC = 3'd4,
    ERR_PROC_NOT_LEAF = 3'd5,
    ERR_TOP_PARENT    = 3'd6
  } err_t;

  typedef struct packed {
    logic        list_start;
    logic [15:0] node_index;
    logic [7:0]  node_kind;
    logic [15:0] parent_node;
  } node_t;

  typedef struct packed {
    logic still_valid;
    err_t error_code;
    logic list_done;
  } verdict_t;

endpackage

>>> design/topology_order_validator_top.sv
// Topology order validator top level: input beat register, check stage, result register.
// Depends on tovl_pkg and tovl_check.
// A beat is held in the input register; its verdict is registered for the master side.
// One node per cycle unless m_tready stalls; stack update and checks are combinational.
// Reset (rst, synchronous): stack all no-parent, level 0, type undefined, no error,
// both beat registers empty.
`timescale 1ns / 1ps

module topology_order_validator_top
  import tovl_pkg::*;
#(
  parameter int MAX_DEPTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // node_index[15:0], node_kind[23:16], parent_node[39:24]
  input  logic        s_tuser,   // list_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // still_valid[0], error_code[3:1], zero[7:4]
  output logic        m_tlast    // list_done
);

  logic     in_valid;
  node_t    in_node;
  logic     advance;
  verdict_t verdict;
  verdict_t out_verdict;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_node.list_start  <= s_tuser;
      in_node.node_index  <= s_tdata[15:0];
      in_node.node_kind   <= s_tdata[23:16];
      in_node.parent_node <= s_tdata[39:24];
    end
  end

  tovl_check #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_check (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .node   (in_node),
    .verdict(verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_verdict <= verdict;
    end
  end

  assign m_tdata = {4'd0, out_verdict.error_code, out_verdict.still_valid};
  assign m_tlast = out_verdict.list_done;

endmodule

>>> design/tovl_check.sv
// Per-level parent stack, level/type state and the rule checks for one node.
// Depends on tovl_pkg. Verdict is combinational; state advances on step.
`timescale 1ns / 1ps

module tovl_check
  import tovl_pkg::*;
#(
  parameter int MAX_DEPTH = 20
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  node_t    node,
  output verdict_t verdict
);

  localparam int LW = $clog2(MAX_DEPTH);

  logic [15:0]          level_parent [MAX_DEPTH];
  logic [15:0]          level_parent_next [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] occupied;
  logic [MAX_DEPTH-1:0] occupied_next;
  logic [15:0]          top_parent;
  logic [15:0]          top_parent_next;
  logic [LW-1:0]        level;
  logic [LW-1:0]        level_next;
  logic [7:0]           level_type;
  logic [7:0]           level_type_next;
  err_t                 latched_error;
  err_t                 latched_error_next;

  // state as seen after an optional list start
  logic [15:0]          eff_top;
  logic [LW-1:0]        eff_level;
  logic [7:0]           eff_type;
  err_t                 eff_err;
  logic [LW:0]          level_p1;
  logic [15:0]          above_par;
  logic [7:0]           cur_type;
  logic                 changed;
  logic                 climb;
  logic                 restart;
  logic                 too_deep;
  logic [LW-1:0]        new_level;
  logic [LW-1:0]        new_level_p1;
  logic [15:0]          par_at;
  logic [15:0]          new_par;
  logic [MAX_DEPTH-1:0] occ_after;
  logic                 top_open;
  err_t                 code;

  always_comb begin
    eff_top   = node.list_start ? NO_PARENT : top_parent;
    eff_level = node.list_start ? '0 : level;
    eff_type  = node.list_start ? TYPE_UNDEFINED : level_type;
    eff_err   = node.list_start ? ERR_NONE : latched_error;

    level_p1  = {1'b0, eff_level} + (LW+1)'(1);
    too_deep  = level_p1 >= (LW+1)'(MAX_DEPTH);
    above_par = (node.list_start || too_deep) ? NO_PARENT : level_parent[level_p1[LW-1:0]];

    cur_type = (eff_type == TYPE_UNDEFINED) ? node.node_kind : eff_type;
    changed  = cur_type != node.node_kind;
    climb    = changed && (node.node_index == eff_top);
    restart  = changed && !climb && (node.node_kind == TYPE_PROCESSOR);

    if (climb) begin
      new_level = level_p1[LW-1:0];
      par_at    = above_par;
    end else if (restart) begin
      new_level = '0;
      par_at    = (eff_level == '0) ? eff_top : NO_PARENT;
    end else begin
      new_level = eff_level;
      par_at    = eff_top;
    end
    new_par      = (par_at == NO_PARENT) ? node.parent_node : par_at;
    new_level_p1 = new_level + LW'(1);

    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (node.list_start || (restart && (LW'(i) < eff_level))) begin
        level_parent_next[i] = NO_PARENT;
        occ_after[i]         = 1'b0;
      end else begin
        level_parent_next[i] = level_parent[i];
        occ_after[i]         = occupied[i];
      end
      if (LW'(i) == new_level) begin
        level_parent_next[i] = new_par;
        occ_after[i]         = new_par != NO_PARENT;
      end
    end

    top_open = (new_level == LW'(MAX_DEPTH - 1)) || !occ_after[new_level_p1];

    if (climb && too_deep) begin
      code = ERR_TOO_DEEP;
    end else if (changed && !climb && !restart) begin
      code = ERR_BAD_ORDER;
    end else if (par_at != NO_PARENT && par_at != node.parent_node) begin
      code = ERR_PARENT;
    end else if (new_level == '0 && node.node_kind != TYPE_PROCESSOR) begin
      code = ERR_LEAF_NOT_PROC;
    end else if (new_level != '0 && node.node_kind == TYPE_PROCESSOR) begin
      code = ERR_PROC_NOT_LEAF;
    end else if (node.node_index == 16'd0 && new_par != NO_PARENT && top_open) begin
      code = ERR_TOP_PARENT;
    end else begin
      code = ERR_NONE;
    end

    // state only matters while no error is latched
    if (eff_err == ERR_NONE && code == ERR_NONE) begin
      occupied_next      = occ_after;
      top_parent_next    = new_par;
      level_next         = new_level;
      level_type_next    = node.node_kind;
      latched_error_next = ERR_NONE;
    end else begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        level_parent_next[i] = node.list_start ? NO_PARENT : level_parent[i];
      end
      occupied_next      = node.list_start ? '0 : occupied;
      top_parent_next    = eff_top;
      level_next         = eff_level;
      level_type_next    = eff_type;
      latched_error_next = (eff_err != ERR_NONE) ? eff_err : code;
    end

    verdict.still_valid = latched_error_next == ERR_NONE;
    verdict.error_code  = latched_error_next;
    verdict.list_done   = node.node_index == 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        level_parent[i] <= NO_PARENT;
      end
      occupied      <= '0;
      top_parent    <= NO_PARENT;
      level         <= '0;
      level_type    <= TYPE_UNDEFINED;
      latched_error <= ERR_NONE;
    end else if (step) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        level_parent[i] <= level_parent_next[i];
      end
      occupied      <= occupied_next;
      top_parent    <= top_parent_next;
      level         <= level_next;
      level_type    <= level_type_next;
      latched_error <= latched_error_next;
    end
  end

endmodule
